@@ hdl/sld_pkg.sv @@
// Shared types and constants for the sync/length packet deframer.
// No dependencies; used by sld_parser and sync_length_packet_deframer_top.
package sld_pkg;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'd155;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'd185;
    localparam logic [7:0] TYPE_CONTROL      = 8'h08;
    localparam logic [7:0] SUBTYPE_THRUSTER  = 8'h11;

    localparam int OUT_PAYLOAD_FIELDS = 6;
    localparam int CNT_W              = 9;

    // Frame positions
    localparam logic [CNT_W-1:0] POS_TYPE    = 9'd2;
    localparam logic [CNT_W-1:0] POS_SUBTYPE = 9'd3;
    localparam int               POS_PAYLOAD = 5;
    localparam int               CHECKSUM_BYTES = 2;

    // Register index, taken from paddr[2]
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } sld_cfg_t;

    typedef struct packed {
        logic [7:0]                              frame_type;
        logic [7:0]                              frame_subtype;
        logic [7:0]                              payload_len;
        logic                                    thruster_cmd;
        logic [OUT_PAYLOAD_FIELDS-1:0][7:0]      thrust;
    } sld_result_t;

endpackage

@@ hdl/sld_parser.sv @@
// Frame parser: hunts for the sync pair, holds the header and the first payload bytes.
// Depends on sld_pkg; gives one result on the byte that completes a frame.
module sld_parser #(
    parameter int KEPT_PAYLOAD_BYTES = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  sld_pkg::sld_cfg_t    cfg,
    output logic                 res_valid,
    output sld_pkg::sld_result_t res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC1,
        PH_HEADER,
        PH_BODY
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [sld_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [7:0]                    len_reg, len_next;
    logic [7:0]                    type_reg, type_next;
    logic [7:0]                    subtype_reg, subtype_next;
    logic [KEPT_PAYLOAD_BYTES-1:0][7:0] head_reg, head_next;
    logic [sld_pkg::CNT_W-1:0]     count_inc;
    logic                          last_byte;

    assign count_inc = count_reg + 9'd1;
    // Last byte of a frame sits at position L + 6
    assign last_byte = count_reg >= ({1'b0, len_reg}
                       + 9'(sld_pkg::POS_PAYLOAD + sld_pkg::CHECKSUM_BYTES - 1));

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        subtype_next = subtype_reg;
        head_next    = head_reg;
        res_valid    = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == cfg.sync_first)
                    begin
                        head_next    = '0;
                        type_next    = '0;
                        subtype_next = '0;
                        len_next     = '0;
                        count_next   = 9'd1;
                        phase_next   = PH_SYNC1;
                    end
                end
                PH_SYNC1:
                begin
                    if (rx_byte == cfg.sync_second)
                    begin
                        count_next = 9'd2;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        count_next = '0;
                        phase_next = PH_HUNT;
                    end
                end
                PH_HEADER:
                begin
                    if (count_reg == sld_pkg::POS_TYPE)
                        type_next = rx_byte;
                    else if (count_reg == sld_pkg::POS_SUBTYPE)
                        subtype_next = rx_byte;
                    else
                    begin
                        len_next   = rx_byte;
                        phase_next = PH_BODY;
                    end
                    count_next = count_inc;
                end
                PH_BODY:
                begin
                    for (int k = 0; k < KEPT_PAYLOAD_BYTES; k++)
                    begin
                        if (count_reg == 9'(sld_pkg::POS_PAYLOAD + k) && len_reg > 8'(k))
                            head_next[k] = rx_byte;
                    end
                    if (last_byte)
                    begin
                        res_valid  = 1'b1;
                        count_next = '0;
                        phase_next = PH_HUNT;
                    end
                    else
                        count_next = count_inc;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Result fields read the held header; no payload byte lands on the last byte
    always_comb
    begin
        res.frame_type    = type_reg;
        res.frame_subtype = subtype_reg;
        res.payload_len   = len_reg;
        res.thruster_cmd  = (type_reg == sld_pkg::TYPE_CONTROL)
                            && (subtype_reg == sld_pkg::SUBTYPE_THRUSTER);
        for (int j = 0; j < sld_pkg::OUT_PAYLOAD_FIELDS; j++)
        begin
            if (j < KEPT_PAYLOAD_BYTES)
                res.thrust[j] = head_reg[j];
            else
                res.thrust[j] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            subtype_reg <= '0;
            head_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            subtype_reg <= subtype_next;
            head_reg    <= head_next;
        end
    end

endmodule

@@ hdl/sync_length_packet_deframer_top.sv @@
// Channel    | Dir | Handshake            | Payload
// input      | in  | in_valid / in_stall  | rx_byte
// result     | out | out_valid / out_stall| frame header, thruster_cmd, thrust_a..f
// config     | in  | APB psel/penable     | sync_first (0x0), sync_second (0x4)
//
// One byte is taken every cycle while in_stall is low; the parser updates in that same cycle.
// A result is registered in the output register, or in the skid entry if the output stalls.
// Output register plus one skid entry: in_stall rises only when both hold results.
// rst_n clears the frame state and restores the sync values; no clearing pass.
// Top level of the deframer; depends on sld_pkg and sld_parser.
module sync_length_packet_deframer_top #(
    parameter int KEPT_PAYLOAD_BYTES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_type,
    output logic [7:0]  frame_subtype,
    output logic [7:0]  payload_len,
    output logic        thruster_cmd,
    output logic [7:0]  thrust_a,
    output logic [7:0]  thrust_b,
    output logic [7:0]  thrust_c,
    output logic [7:0]  thrust_d,
    output logic [7:0]  thrust_e,
    output logic [7:0]  thrust_f,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sld_pkg::sld_cfg_t    cfg_reg;
    sld_pkg::sld_result_t res;
    sld_pkg::sld_result_t out_reg;
    sld_pkg::sld_result_t skid_reg;
    logic                 res_valid;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_xfer;
    logic                 out_free;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_stall  = skid_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= sld_pkg::SYNC_FIRST_RESET;
            cfg_reg.sync_second <= sld_pkg::SYNC_SECOND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sld_pkg::REG_SYNC_FIRST:  cfg_reg.sync_first  <= pwdata[7:0];
                sld_pkg::REG_SYNC_SECOND: cfg_reg.sync_second <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sld_pkg::REG_SYNC_FIRST:  prdata = {24'd0, cfg_reg.sync_first};
            sld_pkg::REG_SYNC_SECOND: prdata = {24'd0, cfg_reg.sync_second};
            default:                  prdata = '0;
        endcase
    end

    sld_parser #(
        .KEPT_PAYLOAD_BYTES (KEPT_PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register drains the skid entry first; a blocked result goes to the skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_reg       <= res;
                out_valid_reg <= in_xfer && res_valid;
            end
        end
        else if (in_xfer && res_valid)
        begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_type    = out_reg.frame_type;
    assign frame_subtype = out_reg.frame_subtype;
    assign payload_len   = out_reg.payload_len;
    assign thruster_cmd  = out_reg.thruster_cmd;
    assign thrust_a      = out_reg.thrust[0];
    assign thrust_b      = out_reg.thrust[1];
    assign thrust_c      = out_reg.thrust[2];
    assign thrust_d      = out_reg.thrust[3];
    assign thrust_e      = out_reg.thrust[4];
    assign thrust_f      = out_reg.thrust[5];

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_valid_reg && !out_stall)
        |=> (out_valid && frame_type == $past(skid_reg.frame_type)
             && payload_len == $past(skid_reg.payload_len)))
        else $error("skid entry not moved to output");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && res_valid && !out_valid_reg) |=> out_valid)
        else $error("completed frame did not reach the output");
`endif

endmodule
